// ===== sv/foc_clarke_park_transform_core_defines.svh =====
// Assertion macros used by the checker file of the transform core.
`ifndef FOC_CLARKE_PARK_TRANSFORM_CORE_DEFINES_SVH
`define FOC_CLARKE_PARK_TRANSFORM_CORE_DEFINES_SVH

// Overlapping implication, sampled on the rising clock, off during reset.
`define FOC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transform core assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transform core assertion failed");

`endif

// ===== sv/foc_cpt_pkg.sv =====
// Constants, codes and trig table builder for the Clarke/Park transform core.
`timescale 1ns / 1ps

package foc_cpt_pkg;

    localparam int ANGLE_STEPS = 360;
    localparam int SAMPLE_BITS = 16;

    localparam int ANGLE_W    = 9;
    localparam int TRIG_DEPTH = 2 ** ANGLE_W;
    localparam int DATA_W     = 16;
    localparam int ACT_W      = 2;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 48;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_FWD_CLARKE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INV_CLARKE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FWD_PARK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_INV_PARK   = 2'd3;

    // sqrt(3) and 2*sqrt(3) in Q15
    localparam logic signed [18:0] Q15_SQRT3   = 19'sd56756;
    localparam logic signed [18:0] Q15_2SQRT3  = 19'sd113512;
    // ceil(2^19 / 3): exact quotient for magnitudes below 2^17
    localparam logic [17:0]        RECIP3      = 18'd174763;
    localparam int                 RECIP3_SH   = 19;

    localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42,
                                                   64'd72, 64'd110, 64'd156};

    typedef logic signed [DATA_W-1:0] t_trig_rom [TRIG_DEPTH];

    // Q15 sine of a quadrant and a position inside that quadrant.
    function automatic logic signed [DATA_W-1:0] sine_part(longint unsigned quad_in,
                                                           longint unsigned rem_in);
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned mag;
        longint          sum;
        longint          val;
        quad = quad_in & 64'd3;
        rem  = rem_in;
        if (quad[0]) begin
            rem = longint'(ANGLE_STEPS) - rem;
        end
        x   = (rem * HALF_PI_Q30) / ANGLE_STEPS;
        x2  = (x * x) >> 30;
        mag = x;
        sum = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            mag = ((mag * x2) >> 30) / TAYLOR_DIV[n-1];
            if (n[0]) begin
                sum = sum - longint'(mag);
            end else begin
                sum = sum + longint'(mag);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        val = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
        if (val > 64'sd32767) begin
            val = 64'sd32767;
        end
        return (quad >= 64'd2) ? DATA_W'(-val) : DATA_W'(val);
    endfunction

    // Table over every raw angle code; the code wraps modulo the turn.
    function automatic t_trig_rom build_trig_rom(longint unsigned quad_offset);
        t_trig_rom       rom;
        longint unsigned r;
        for (int k = 0; k < TRIG_DEPTH; k++) begin
            r = longint'(k % ANGLE_STEPS) * 64'd4;
            rom[k] = sine_part(r / ANGLE_STEPS + quad_offset, r % ANGLE_STEPS);
        end
        return rom;
    endfunction

endpackage

// ===== sv/foc_clarke_park_transform_core.sv =====
// Q15 Clarke/Park transform core: four-stage pipeline with a streaming interface.
// Throughput: one word per cycle unless the output stalls; every stage holds one word and its valid bit.
// The sine/cosine ROM read is registered in stage 1; multipliers sit in stage 2.
// Reset: synchronous, active low; clears the stage valid bits only.
`timescale 1ns / 1ps

module foc_clarke_park_transform_core
    import foc_cpt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [15:0] first_in, [31:16] second_in, [40:32] angle_deg, [47:41] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]       i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [15:0] out_x, [31:16] out_y, [47:32] out_z
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam t_trig_rom SIN_ROM = build_trig_rom(64'd0);
    localparam t_trig_rom COS_ROM = build_trig_rom(64'd1);

    function automatic logic [DATA_W-1:0] sat_sample(logic signed [19:0] v);
        logic [DATA_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage 1
    logic                     r_s1_valid;
    logic [ACT_W-1:0]         r_s1_act;
    logic signed [DATA_W-1:0] r_s1_a, r_s1_b, r_s1_sin, r_s1_cos;
    // stage 2
    logic                     r_s2_valid;
    logic [ACT_W-1:0]         r_s2_act;
    logic signed [DATA_W-1:0] r_s2_a;
    logic signed [19:0]       r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4;
    // stage 3
    logic                     r_s3_valid;
    logic [ACT_W-1:0]         r_s3_act;
    logic signed [19:0]       r_s3_x, r_s3_y, r_s3_z;
    logic [15:0]              r_s3_q1, r_s3_q2;
    logic                     r_s3_neg1, r_s3_neg2;
    // stage 4 (output register)
    logic                     r_s4_valid;
    logic [DATA_W-1:0]        r_s4_x, r_s4_y, r_s4_z;

    assign w_rdy4     = !r_s4_valid || i_m_tready;
    assign w_rdy3     = !r_s3_valid || w_rdy4;
    assign w_rdy2     = !r_s2_valid || w_rdy3;
    assign w_rdy1     = !r_s1_valid || w_rdy2;
    assign o_s_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    // Stage 1: capture the word and read sine/cosine
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_act <= i_s_tuser;
            r_s1_a   <= i_s_tdata[15:0];
            r_s1_b   <= i_s_tdata[31:16];
            r_s1_sin <= SIN_ROM[i_s_tdata[32 +: ANGLE_W]];
            r_s1_cos <= COS_ROM[i_s_tdata[32 +: ANGLE_W]];
        end
    end

    // Stage 2: four shared multipliers, floored Q15 products
    logic signed [18:0] n_s2_k1, n_s2_k2;
    logic signed [16:0] n_s2_a3;
    logic signed [34:0] n_s2_m1, n_s2_m2, n_s2_m3, n_s2_m4;

    always_comb begin
        n_s2_k1 = (r_s1_act == ACT_FWD_CLARKE) ? Q15_SQRT3 : 19'(r_s1_cos);
        case (r_s1_act)
            ACT_FWD_CLARKE: n_s2_k2 = Q15_2SQRT3;
            ACT_INV_CLARKE: n_s2_k2 = Q15_SQRT3;
            default:        n_s2_k2 = 19'(r_s1_sin);
        endcase
        n_s2_a3 = (r_s1_act == ACT_FWD_PARK) ? -17'(r_s1_a) : 17'(r_s1_a);
        n_s2_m1 = 35'(r_s1_a) * 35'(n_s2_k1);
        n_s2_m2 = 35'(r_s1_b) * 35'(n_s2_k2);
        n_s2_m3 = 35'(n_s2_a3) * 35'(r_s1_sin);
        n_s2_m4 = 35'(r_s1_b) * 35'(r_s1_cos);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_act <= r_s1_act;
            r_s2_a   <= r_s1_a;
            r_s2_p1  <= n_s2_m1[34:15];
            r_s2_p2  <= n_s2_m2[34:15];
            r_s2_p3  <= n_s2_m3[34:15];
            r_s2_p4  <= n_s2_m4[34:15];
        end
    end

    // Stage 3: sums for Park and inverse Clarke, divide by three for forward Clarke
    logic [19:0]        n_s3_abs1, n_s3_abs2;
    logic [34:0]        n_s3_d1, n_s3_d2;
    logic signed [19:0] n_s3_t1, n_s3_t2;
    logic [19:0]        n_s3_h1, n_s3_h2;
    logic signed [19:0] n_s3_x, n_s3_y, n_s3_z;

    always_comb begin
        n_s3_abs1 = r_s2_p1[19] ? 20'(-r_s2_p1) : 20'(r_s2_p1);
        n_s3_abs2 = r_s2_p2[19] ? 20'(-r_s2_p2) : 20'(r_s2_p2);
        n_s3_d1   = 35'(n_s3_abs1[16:0]) * 35'(RECIP3);
        n_s3_d2   = 35'(n_s3_abs2[16:0]) * 35'(RECIP3);
        // halve toward zero: bias negative sums by one before the shift
        n_s3_t1   = -20'(r_s2_a) + r_s2_p2;
        n_s3_t2   = -20'(r_s2_a) - r_s2_p2;
        n_s3_h1   = n_s3_t1 + 20'(n_s3_t1[19]);
        n_s3_h2   = n_s3_t2 + 20'(n_s3_t2[19]);
        n_s3_x    = 20'(r_s2_a);
        n_s3_y    = '0;
        n_s3_z    = '0;
        case (r_s2_act)
            ACT_FWD_CLARKE: begin
                n_s3_x = 20'(r_s2_a);
            end
            ACT_INV_CLARKE: begin
                n_s3_y = {n_s3_h1[19], n_s3_h1[19:1]};
                n_s3_z = {n_s3_h2[19], n_s3_h2[19:1]};
            end
            ACT_FWD_PARK: begin
                n_s3_x = r_s2_p1 + r_s2_p2;
                n_s3_y = r_s2_p3 + r_s2_p4;
            end
            default: begin
                n_s3_x = r_s2_p1 - r_s2_p2;
                n_s3_y = r_s2_p3 + r_s2_p4;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_act  <= r_s2_act;
            r_s3_x    <= n_s3_x;
            r_s3_y    <= n_s3_y;
            r_s3_z    <= n_s3_z;
            r_s3_q1   <= n_s3_d1[RECIP3_SH +: 16];
            r_s3_q2   <= n_s3_d2[RECIP3_SH +: 16];
            r_s3_neg1 <= r_s2_p1[19];
            r_s3_neg2 <= r_s2_p2[19];
        end
    end

    // Stage 4: restore quotient signs, select and saturate
    logic signed [19:0] n_s4_q1, n_s4_q2, n_s4_y;

    always_comb begin
        n_s4_q1 = r_s3_neg1 ? -$signed({4'b0, r_s3_q1}) : $signed({4'b0, r_s3_q1});
        n_s4_q2 = r_s3_neg2 ? -$signed({4'b0, r_s3_q2}) : $signed({4'b0, r_s3_q2});
        n_s4_y  = (r_s3_act == ACT_FWD_CLARKE) ? (n_s4_q1 + n_s4_q2) : r_s3_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_x <= sat_sample(r_s3_x);
            r_s4_y <= sat_sample(n_s4_y);
            r_s4_z <= sat_sample(r_s3_z);
        end
    end

    assign o_m_tvalid = r_s4_valid;
    assign o_m_tdata  = {r_s4_z, r_s4_y, r_s4_x};

endmodule

// ===== sv/foc_cpt_checker.sv =====
// Port-level checker for the transform core and its bind.
`timescale 1ns / 1ps
`include "foc_clarke_park_transform_core_defines.svh"

module foc_cpt_checker
    import foc_cpt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic [ACT_W-1:0]       i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic w_in_acc;
    logic w_in_stall;
    logic w_out_stall;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_in_stall  = i_s_tvalid && !o_s_tready;
    assign w_out_stall = o_m_tvalid && !i_m_tready;

    // a stalled result word stays put
    `FOC_ASSERT_NEXT(a_out_hold_valid, i_clk, i_rst_n, w_out_stall, o_m_tvalid)
    `FOC_ASSERT_NEXT(a_out_hold_data, i_clk, i_rst_n, w_out_stall, $stable(o_m_tdata))
    // a refused input word stays put
    `FOC_ASSERT_NEXT(a_in_hold_data, i_clk, i_rst_n, w_in_stall, $stable({i_s_tuser, i_s_tdata}))
    // with no word waiting at the output, the whole pipe advances
    `FOC_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)
    // an accepted word reaches the output if the output stays ready meanwhile
    `FOC_ASSERT_NEXT(a_latency, i_clk, i_rst_n, w_in_acc ##1 i_m_tready [*3], o_m_tvalid)

endmodule

bind foc_clarke_park_transform_core foc_cpt_checker u_foc_cpt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
